// ===== hdl/bole_pkg.sv =====
// Shared constants, codes and the cell control word for the bounded ordered list engine.
// Used by bole_cell and bounded_ordered_list_engine; depends on nothing else.
`default_nettype none

package bole_pkg;

  // Capacity bounds and the default
  localparam int CAPACITY_DEF = 128;
  localparam int CAPACITY_MAX = 1024;

  // Field widths
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int POS_W     = 8;
  localparam int CNT_OUT_W = 8;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;

  // Index word wide enough for any position up to the largest capacity
  localparam int IDX_W  = $clog2(CAPACITY_MAX + 1);
  // Sweep step index, enough for log2 of the largest capacity
  localparam int STEP_W = 4;
  // Gathered word: found flag, key, payload
  localparam int ACC_W  = 1 + KEY_W + PAY_W;

  // Opcodes
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_KEY  = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_POS = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOKEY  = 2'd3;

  // Cell phases
  localparam logic [2:0] PH_HOLD   = 3'd0;
  localparam logic [2:0] PH_MATCH  = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_GSTART = 3'd3;
  localparam logic [2:0] PH_GATHER = 3'd4;
  localparam logic [2:0] PH_INSERT = 3'd5;
  localparam logic [2:0] PH_DELETE = 3'd6;

  // Control word broadcast to every cell
  typedef struct packed {
    logic [2:0]        phase;
    logic [STEP_W-1:0] step;
    logic              key_mode;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/bole_cell.sv =====
// One list cell: holds one key and payload, matches, runs the prefix and gather sweeps
// and shifts with its neighbors. Depends on bole_pkg.
`default_nettype none

module bole_cell #(
  parameter int INDEX = 0,
  parameter int STEPS = 1
) (
  input  wire logic                        clk,
  input  wire bole_pkg::ctl_t              ctl,
  input  wire logic                        valid,
  input  wire logic [bole_pkg::KEY_W-1:0]  left_key,
  input  wire logic [bole_pkg::PAY_W-1:0]  left_pay,
  input  wire logic [bole_pkg::KEY_W-1:0]  right_key,
  input  wire logic [bole_pkg::PAY_W-1:0]  right_pay,
  input  wire logic                        left_g,
  input  wire logic                        g_in [STEPS],
  input  wire logic [bole_pkg::ACC_W-1:0]  acc_in [STEPS],
  output logic      [bole_pkg::KEY_W-1:0]  key,
  output logic      [bole_pkg::PAY_W-1:0]  payload,
  output logic                             g,
  output logic      [bole_pkg::ACC_W-1:0]  acc
);

  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [bole_pkg::IDX_W-1:0] ME = bole_pkg::IDX_W'(INDEX);

  logic          hit;
  logic          match;
  logic          first;
  logic [SW-1:0] k;

  assign k = ctl.step[SW-1:0];

  // Match on key or on position, only for live entries
  assign match = valid & (ctl.key_mode ? (key == ctl.key) : (ME == ctl.idx));

  // First hit: hit here and none to the left
  assign first = hit & ~left_g;

  always_ff @(posedge clk) begin
    case (ctl.phase)
      bole_pkg::PH_MATCH: begin
        hit <= match;
        g   <= match;
      end
      // Fold in the prefix from 2^k cells to the left
      bole_pkg::PH_PREFIX: begin
        g <= g | g_in[k];
      end
      bole_pkg::PH_GSTART: begin
        acc <= first ? {1'b1, key, payload} : '0;
      end
      // Pull the gathered word from 2^k cells to the right
      bole_pkg::PH_GATHER: begin
        acc <= acc | acc_in[k];
      end
      // Open a gap at the insert index and drop the new word in
      bole_pkg::PH_INSERT: begin
        if (ME > ctl.idx) begin
          key     <= left_key;
          payload <= left_pay;
        end else if (ME == ctl.idx) begin
          key     <= ctl.key;
          payload <= ctl.payload;
        end
      end
      // Close the gap from the first hit onward
      bole_pkg::PH_DELETE: begin
        if (g) begin
          key     <= right_key;
          payload <= right_pay;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bounded_ordered_list_engine.sv =====
// Append, insert, unused opcodes and out-of-range positions go from accept straight
// to the apply state; find, delete by key and in-range delete or read at position run
// the match state, the log-step prefix sweep, the gather start state and the log-step
// gather sweep across the cell row before apply. Done is registered from the apply state.
// One word at a time: start is ignored while busy; busy drops in the done cycle.
// Reset: count cleared, contents undefined until written. Top; uses bole_pkg, bole_cell.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [bole_pkg::OP_W-1:0]  opcode,
  input  wire logic signed [bole_pkg::KEY_W-1:0] entry_key,
  input  wire logic        [bole_pkg::PAY_W-1:0] entry_payload,
  input  wire logic        [bole_pkg::POS_W-1:0] position,
  output logic                                   done,
  output logic        [bole_pkg::STAT_W-1:0]     status,
  output logic signed [bole_pkg::KEY_W-1:0]      found_key,
  output logic        [bole_pkg::PAY_W-1:0]      found_payload,
  output logic        [bole_pkg::CNT_OUT_W-1:0]  entry_count,
  output logic                                   is_empty,
  output logic                                   is_full
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMPW  = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;
  localparam int STEPS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int KW    = bole_pkg::KEY_W;
  localparam int PW    = bole_pkg::PAY_W;
  localparam int AW    = bole_pkg::ACC_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_PREFIX = 3'd2;
  localparam logic [2:0] S_GSTART = 3'd3;
  localparam logic [2:0] S_GATHER = 3'd4;
  localparam logic [2:0] S_APPLY  = 3'd5;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [SW-1:0]               step;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [bole_pkg::OP_W-1:0]   req_op;
  logic [KW-1:0]               req_key;
  logic [PW-1:0]               req_pay;
  logic [bole_pkg::POS_W-1:0]  req_pos;

  logic                        accept;
  logic                        needs_search;
  logic                        last_step;
  logic                        list_full;
  logic                        req_pos_lt;
  logic                        req_pos_le;
  logic                        found;
  logic                        apply_ins;
  logic                        apply_del;
  logic                        take_data;
  logic [bole_pkg::STAT_W-1:0] res_status;
  bole_pkg::ctl_t              ctl;

  logic [KW-1:0] cell_key   [CAPACITY];
  logic [PW-1:0] cell_pay   [CAPACITY];
  logic          cell_g     [CAPACITY];
  logic [AW-1:0] cell_acc   [CAPACITY];
  logic          cell_valid [CAPACITY];

  assign busy      = (state != S_IDLE);
  assign accept    = start & ~busy;
  assign last_step = (step == SW'(STEPS - 1));
  assign list_full = (count == CW'(CAPACITY));
  assign found     = cell_acc[0][AW-1];

  assign req_pos_lt = (CMPW'(req_pos) < CMPW'(count));
  assign req_pos_le = (CMPW'(req_pos) <= CMPW'(count));

  // Decide at accept whether the word needs the cell sweeps
  always_comb begin
    case (opcode)
      bole_pkg::OP_DEL_KEY, bole_pkg::OP_FIND: needs_search = 1'b1;
      bole_pkg::OP_DEL_POS, bole_pkg::OP_READ_POS:
        needs_search = (CMPW'(position) < CMPW'(count));
      default: needs_search = 1'b0;
    endcase
  end

  // Sequence the sweeps
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = needs_search ? S_MATCH : S_APPLY;
        end
      end
      S_MATCH:  state_next = S_PREFIX;
      S_PREFIX: state_next = last_step ? S_GSTART : S_PREFIX;
      S_GSTART: state_next = S_GATHER;
      S_GATHER: state_next = last_step ? S_APPLY : S_GATHER;
      S_APPLY:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Resolve status and the list edit for the held word
  always_comb begin
    res_status = bole_pkg::STAT_DONE;
    apply_ins  = 1'b0;
    apply_del  = 1'b0;
    take_data  = 1'b0;
    case (req_op)
      bole_pkg::OP_APPEND: begin
        if (list_full) res_status = bole_pkg::STAT_FULL;
        else           apply_ins  = 1'b1;
      end
      bole_pkg::OP_INSERT: begin
        if (list_full)        res_status = bole_pkg::STAT_FULL;
        else if (!req_pos_le) res_status = bole_pkg::STAT_BADPOS;
        else                  apply_ins  = 1'b1;
      end
      bole_pkg::OP_DEL_POS: begin
        if (!req_pos_lt) res_status = bole_pkg::STAT_BADPOS;
        else             apply_del  = 1'b1;
      end
      bole_pkg::OP_READ_POS: begin
        if (!req_pos_lt) res_status = bole_pkg::STAT_BADPOS;
        else             take_data  = 1'b1;
      end
      bole_pkg::OP_DEL_KEY: begin
        if (found) apply_del  = 1'b1;
        else       res_status = bole_pkg::STAT_NOKEY;
      end
      bole_pkg::OP_FIND: begin
        if (found) take_data  = 1'b1;
        else       res_status = bole_pkg::STAT_NOKEY;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (apply_ins)      count_next = count + CW'(1);
    else if (apply_del) count_next = count - CW'(1);
  end

  // Build the control word for the cell row
  always_comb begin
    ctl.step     = bole_pkg::STEP_W'(step);
    ctl.key_mode = (req_op == bole_pkg::OP_DEL_KEY) || (req_op == bole_pkg::OP_FIND);
    ctl.idx      = (req_op == bole_pkg::OP_APPEND) ? bole_pkg::IDX_W'(count)
                                                   : bole_pkg::IDX_W'(req_pos);
    ctl.key      = req_key;
    ctl.payload  = req_pay;
    unique case (state)
      S_MATCH:  ctl.phase = bole_pkg::PH_MATCH;
      S_PREFIX: ctl.phase = bole_pkg::PH_PREFIX;
      S_GSTART: ctl.phase = bole_pkg::PH_GSTART;
      S_GATHER: ctl.phase = bole_pkg::PH_GATHER;
      S_APPLY: begin
        if (apply_ins)      ctl.phase = bole_pkg::PH_INSERT;
        else if (apply_del) ctl.phase = bole_pkg::PH_DELETE;
        else                ctl.phase = bole_pkg::PH_HOLD;
      end
      default:  ctl.phase = bole_pkg::PH_HOLD;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_APPLY);
      if (state == S_APPLY) begin
        count <= count_next;
      end
      if ((state == S_PREFIX) || (state == S_GATHER)) begin
        step <= last_step ? '0 : step + SW'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // Hold the accepted word and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= opcode;
      req_key <= entry_key;
      req_pay <= entry_payload;
      req_pos <= position;
    end
    if (state == S_APPLY) begin
      status        <= res_status;
      found_key     <= take_data ? cell_acc[0][KW+PW-1:PW] : '0;
      found_payload <= take_data ? cell_acc[0][PW-1:0] : '0;
      entry_count   <= bole_pkg::CNT_OUT_W'(count_next);
      is_empty      <= (count_next == '0);
      is_full       <= (count_next == CW'(CAPACITY));
    end
  end

  // Row of cells with fixed neighbor taps
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          g_nb   [STEPS];
    logic [AW-1:0] acc_nb [STEPS];
    logic [KW-1:0] l_key;
    logic [PW-1:0] l_pay;
    logic [KW-1:0] r_key;
    logic [PW-1:0] r_pay;
    logic          l_g;

    assign cell_valid[i] = (CW'(i) < count);

    for (genvar k = 0; k < STEPS; k++) begin : g_tap
      if (i >= (1 << k)) begin : g_lo
        assign g_nb[k] = cell_g[i - (1 << k)];
      end else begin : g_lo_none
        assign g_nb[k] = 1'b0;
      end
      if (i + (1 << k) < CAPACITY) begin : g_hi
        assign acc_nb[k] = cell_acc[i + (1 << k)];
      end else begin : g_hi_none
        assign acc_nb[k] = '0;
      end
    end

    if (i > 0) begin : g_left
      assign l_key = cell_key[i-1];
      assign l_pay = cell_pay[i-1];
      assign l_g   = cell_g[i-1];
    end else begin : g_left_none
      assign l_key = '0;
      assign l_pay = '0;
      assign l_g   = 1'b0;
    end

    if (i < CAPACITY - 1) begin : g_right
      assign r_key = cell_key[i+1];
      assign r_pay = cell_pay[i+1];
    end else begin : g_right_none
      assign r_key = '0;
      assign r_pay = '0;
    end

    bole_cell #(
      .INDEX (i),
      .STEPS (STEPS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (cell_valid[i]),
      .left_key  (l_key),
      .left_pay  (l_pay),
      .right_key (r_key),
      .right_pay (r_pay),
      .left_g    (l_g),
      .g_in      (g_nb),
      .acc_in    (acc_nb),
      .key       (cell_key[i]),
      .payload   (cell_pay[i]),
      .g         (cell_g[i]),
      .acc       (cell_acc[i])
    );
  end

  // Checks
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_APPLY)
    else $error("done without a preceding apply cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_APPLY |=> $stable(count))
    else $error("count changed outside apply");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (done && status == bole_pkg::STAT_FULL) |-> is_full)
    else $error("full status on a list that is not full");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

`default_nettype wire
